// ===== rtl/rpra_pkg.sv =====
// Package for the reference-counted page ring allocator.
// Field widths, request and status codes, sequencer states, divider status.
// No dependencies.
package rpra_pkg;

    localparam int OP_W     = 2;
    localparam int RC_W     = 8;
    localparam int SIZE_W   = 26;
    localparam int OFF_W    = 25;
    localparam int STAT_W   = 2;
    localparam int USED_W   = 13;
    localparam int PB_W     = 17;
    localparam int ACT_W    = 13;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 1;

    // page size in 512-byte units, 1 to 256
    localparam int PM_W     = 9;
    // divider operands
    localparam int DVD_W    = 17;
    localparam int DIV_CNT_W = 5;
    // page count of a request, up to 2^17
    localparam int NW       = 18;

    localparam logic [PB_W-1:0]  PB_RESET  = 17'd1024;
    localparam logic [ACT_W-1:0] ACT_RESET = 13'd4096;
    // 32 MiB / 512
    localparam logic [DVD_W-1:0] LIM_DIVIDEND = 17'd65536;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BYTES   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_PAGES = 1'b1;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    // unused code, answered as an invalid request
    localparam logic [OP_W-1:0] OP_RSVD  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOROOM  = 2'd1;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DLIM, S_DN, S_DOFF, S_ADISP,
        S_SCAN_RD, S_SCAN_CHK, S_WRAP, S_WRAP_CHK, S_FIT_RD, S_FIT_CHK, S_MARK,
        S_FCHK_RD, S_FCHK_CHK, S_FDEC_RD, S_FDEC_WR,
        S_CR_INIT, S_CR1_RD, S_CR1_CHK, S_CR2_RD, S_CR2_CHK,
        S_MUL_G, S_MUL_R, S_MUL_C, S_DONE
    } state_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
        logic [PM_W-1:0]  remainder;
    } div_status_t;

endpackage

// ===== rtl/rpra_if.sv =====
// Request and response channel interfaces for the page ring allocator.
// Depends on rpra_pkg.
interface rpra_req_if;
    logic                         valid;
    logic                         ready;
    logic [rpra_pkg::OP_W-1:0]    op;
    logic [rpra_pkg::RC_W-1:0]    ref_count;
    logic [rpra_pkg::SIZE_W-1:0]  size_bytes;
    logic [rpra_pkg::OFF_W-1:0]   offset_bytes;

    modport source (output valid, op, ref_count, size_bytes, offset_bytes, input ready);
    modport sink   (input valid, op, ref_count, size_bytes, offset_bytes, output ready);
endinterface

interface rpra_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [rpra_pkg::STAT_W-1:0]  status;
    logic [rpra_pkg::SIZE_W-1:0]  granted_offset;
    logic [rpra_pkg::USED_W-1:0]  used_pages;
    logic [rpra_pkg::SIZE_W-1:0]  remaining_bytes;
    logic [rpra_pkg::SIZE_W-1:0]  clean_run_bytes;
    logic                         is_empty;
    logic                         is_full;

    modport source (output valid, status, granted_offset, used_pages, remaining_bytes,
                    clean_run_bytes, is_empty, is_full, input ready);
    modport sink   (input valid, status, granted_offset, used_pages, remaining_bytes,
                    clean_run_bytes, is_empty, is_full, output ready);
endinterface

// ===== rtl/refcounted_page_ring_allocator.sv =====
// Channel  | dir | handshake    | payload
// req      | in  | valid/ready  | op, ref_count, size_bytes, offset_bytes
// rsp      | out | valid/ready  | status, granted_offset, used_pages, remaining_bytes,
//          |     |              | clean_run_bytes, is_empty, is_full
// cfg      | in  | cfg_we only  | cfg_index, cfg_data
// One request at a time: divides and multiplies, plus page-by-page accesses to the
// count memory (busy scan, run check, marking, free check and decrement,
// clean-run scan). Worst case grows with active pages.
// After reset, a clear request or any config write, a clearing pass over all
// NUM_PAGES pages runs with req.ready low. rsp is registered; a new request is taken
// while a result waits, and a finished one waits for rsp.ready.
// Depends on rpra_pkg, rpra_if, rpra_div, rpra_ram.
module refcounted_page_ring_allocator #(
    parameter int NUM_PAGES = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    rpra_req_if.sink                       req,
    rpra_rsp_if.source                     rsp,
    input  logic                           cfg_we,
    input  logic [rpra_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rpra_pkg::CFG_W-1:0]     cfg_data
);
    import rpra_pkg::*;

    localparam int PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int CW = $clog2(NUM_PAGES + 1);

    state_t state_reg, state_next;
    logic [PW-1:0]     clr_addr_reg, clr_addr_next;
    logic              clr_res_reg, clr_res_next;
    logic [PB_W-1:0]   pb_reg, pb_next;
    logic [ACT_W-1:0]  ap_reg, ap_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [RC_W-1:0]   rc_reg, rc_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic [CW-1:0]     act_reg, act_next;
    logic [CW-1:0]     cursor_reg, cursor_next;
    logic [CW-1:0]     used_reg, used_next;
    logic [NW-1:0]     n_reg, n_next;
    logic [DVD_W-1:0]  q_reg, q_next;
    logic [NW-1:0]     i_reg, i_next;
    logic [CW-1:0]     j_reg, j_next;
    logic [CW-1:0]     start_reg, start_next;
    logic [CW-1:0]     run_reg, run_next;
    logic [CW-1:0]     gpage_reg, gpage_next;
    logic              ok_reg, ok_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [SIZE_W-1:0] granted_reg, granted_next;
    logic [SIZE_W-1:0] remain_reg, remain_next;
    logic [SIZE_W-1:0] clean_reg, clean_next;

    logic              rsp_valid_reg, rsp_valid_next;
    logic [STAT_W-1:0] o_status_reg, o_status_next;
    logic [SIZE_W-1:0] o_granted_reg, o_granted_next;
    logic [USED_W-1:0] o_used_reg, o_used_next;
    logic [SIZE_W-1:0] o_remain_reg, o_remain_next;
    logic [SIZE_W-1:0] o_clean_reg, o_clean_next;
    logic              o_empty_reg, o_empty_next;
    logic              o_full_reg, o_full_next;

    logic              mem_we;
    logic [PW-1:0]     mem_waddr, mem_raddr;
    logic [7:0]        mem_wdata, mem_rdata;

    logic              div_start;
    logic [DVD_W-1:0]  div_dividend;
    div_status_t       div_stat;

    logic [17:0]       pb_up;
    logic [PM_W-1:0]   pm;
    logic [31:0]       a1, a2, act_calc;
    logic [31:0]       k32, fk32, used32;
    logic              free_bad;
    logic [CW-1:0]     mul_a;
    logic [CW+PM_W-1:0] mul_p;
    logic [63:0]       prod_sh;
    logic              req_ready;

    // effective page size in 512-byte units; zero becomes one unit
    assign pb_up = 18'(pb_reg) + 18'd511;
    assign pm    = (pb_reg == '0) ? PM_W'(1) : pb_up[17:9];

    rpra_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (pm),
        .stat     (div_stat)
    );

    rpra_ram #(.DEPTH(NUM_PAGES), .AW(PW)) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign req_ready = (state_reg == S_IDLE) && !cfg_we;
    assign req.ready = req_ready;

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = o_status_reg;
    assign rsp.granted_offset  = o_granted_reg;
    assign rsp.used_pages      = o_used_reg;
    assign rsp.remaining_bytes = o_remain_reg;
    assign rsp.clean_run_bytes = o_clean_reg;
    assign rsp.is_empty        = o_empty_reg;
    assign rsp.is_full         = o_full_reg;

    // active page bound: clamp to 1..NUM_PAGES, then to 32 MiB / page size
    always_comb
    begin
        a1       = (ap_reg == '0) ? 32'd1 : 32'(ap_reg);
        a2       = (a1 > 32'(NUM_PAGES)) ? 32'(NUM_PAGES) : a1;
        act_calc = (a2 > 32'(div_stat.quotient)) ? 32'(div_stat.quotient) : a2;
    end

    assign k32    = 32'(cursor_reg) + 32'(i_reg);
    assign fk32   = 32'(q_reg) + 32'(i_reg);
    assign used32 = 32'(used_reg);

    assign free_bad = (off_reg[8:0] != '0) || (div_stat.remainder != '0)
                   || (32'(div_stat.quotient) >= 32'(act_reg))
                   || (32'(n_reg) > 32'(act_reg) - 32'(div_stat.quotient));

    always_comb
    begin
        unique case (state_reg)
            S_MUL_G: mul_a = gpage_reg;
            S_MUL_R: mul_a = act_reg - used_reg;
            default: mul_a = run_reg;
        endcase
    end

    assign mul_p   = mul_a * pm;
    assign prod_sh = 64'(mul_p) << 9;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            clr_res_reg   <= 1'b0;
            pb_reg        <= PB_RESET;
            ap_reg        <= ACT_RESET;
            cursor_reg    <= '0;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            clr_res_reg   <= clr_res_next;
            pb_reg        <= pb_next;
            ap_reg        <= ap_next;
            cursor_reg    <= cursor_next;
            used_reg      <= used_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        rc_reg        <= rc_next;
        size_reg      <= size_next;
        off_reg       <= off_next;
        act_reg       <= act_next;
        n_reg         <= n_next;
        q_reg         <= q_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        start_reg     <= start_next;
        run_reg       <= run_next;
        gpage_reg     <= gpage_next;
        ok_reg        <= ok_next;
        status_reg    <= status_next;
        granted_reg   <= granted_next;
        remain_reg    <= remain_next;
        clean_reg     <= clean_next;
        o_status_reg  <= o_status_next;
        o_granted_reg <= o_granted_next;
        o_used_reg    <= o_used_next;
        o_remain_reg  <= o_remain_next;
        o_clean_reg   <= o_clean_next;
        o_empty_reg   <= o_empty_next;
        o_full_reg    <= o_full_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        clr_res_next   = clr_res_reg;
        pb_next        = pb_reg;
        ap_next        = ap_reg;
        op_next        = op_reg;
        rc_next        = rc_reg;
        size_next      = size_reg;
        off_next       = off_reg;
        act_next       = act_reg;
        cursor_next    = cursor_reg;
        used_next      = used_reg;
        n_next         = n_reg;
        q_next         = q_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        start_next     = start_reg;
        run_next       = run_reg;
        gpage_next     = gpage_reg;
        ok_next        = ok_reg;
        status_next    = status_reg;
        granted_next   = granted_reg;
        remain_next    = remain_reg;
        clean_next     = clean_reg;
        rsp_valid_next = rsp_valid_reg;
        o_status_next  = o_status_reg;
        o_granted_next = o_granted_reg;
        o_used_next    = o_used_reg;
        o_remain_next  = o_remain_reg;
        o_clean_next   = o_clean_reg;
        o_empty_next   = o_empty_reg;
        o_full_next    = o_full_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_raddr      = '0;
        div_start      = 1'b0;
        div_dividend   = '0;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                if (clr_addr_reg == PW'(NUM_PAGES - 1))
                begin
                    state_next   = clr_res_reg ? S_CR_INIT : S_IDLE;
                    clr_res_next = 1'b0;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (req.valid && req_ready)
                begin
                    op_next      = req.op;
                    rc_next      = req.ref_count;
                    size_next    = req.size_bytes;
                    off_next     = req.offset_bytes;
                    status_next  = ST_OK;
                    ok_next      = 1'b0;
                    div_start    = 1'b1;
                    div_dividend = LIM_DIVIDEND;
                    state_next   = S_DLIM;
                end
            end
            S_DLIM:
            begin
                if (div_stat.done)
                begin
                    act_next = CW'(act_calc);
                    if (32'(cursor_reg) > act_calc)
                    begin
                        cursor_next = CW'(act_calc);
                    end
                    div_start    = 1'b1;
                    div_dividend = size_reg[SIZE_W-1:9];
                    state_next   = S_DN;
                end
            end
            S_DN:
            begin
                if (div_stat.done)
                begin
                    n_next = NW'(div_stat.quotient)
                           + NW'((div_stat.remainder != '0) || (size_reg[8:0] != '0));
                    case (op_reg)
                        OP_ALLOC: state_next = S_ADISP;
                        OP_FREE:
                        begin
                            div_start    = 1'b1;
                            div_dividend = DVD_W'(off_reg[OFF_W-1:9]);
                            state_next   = S_DOFF;
                        end
                        OP_CLEAR:
                        begin
                            cursor_next   = '0;
                            used_next     = '0;
                            clr_addr_next = '0;
                            clr_res_next  = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        default:
                        begin
                            status_next = ST_INVALID;
                            state_next  = S_CR_INIT;
                        end
                    endcase
                end
            end
            S_DOFF:
            begin
                if (div_stat.done)
                begin
                    q_next = div_stat.quotient;
                    i_next = '0;
                    if (free_bad)
                    begin
                        status_next = ST_INVALID;
                        state_next  = S_CR_INIT;
                    end
                    else
                    begin
                        state_next = S_FCHK_RD;
                    end
                end
            end
            S_ADISP:
            begin
                if (rc_reg == '0)
                begin
                    status_next = ST_INVALID;
                    state_next  = S_CR_INIT;
                end
                else if (32'(act_reg) - used32 < 32'(n_reg))
                begin
                    status_next = ST_NOROOM;
                    state_next  = S_CR_INIT;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                mem_raddr = cursor_reg[PW-1:0];
                state_next = (cursor_reg >= act_reg) ? S_WRAP : S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (mem_rdata != '0)
                begin
                    cursor_next = cursor_reg + 1'b1;
                    state_next  = S_SCAN_RD;
                end
                else
                begin
                    state_next = S_WRAP;
                end
            end
            S_WRAP:
            begin
                i_next = NW'(1);
                if (32'(cursor_reg) + 32'(n_reg) > 32'(act_reg))
                begin
                    cursor_next = '0;
                    mem_raddr   = '0;
                    state_next  = S_WRAP_CHK;
                end
                else
                begin
                    state_next = S_FIT_RD;
                end
            end
            S_WRAP_CHK:
            begin
                if (mem_rdata != '0)
                begin
                    status_next = ST_NOROOM;
                    state_next  = S_CR_INIT;
                end
                else
                begin
                    state_next = S_FIT_RD;
                end
            end
            S_FIT_RD:
            begin
                mem_raddr = k32[PW-1:0];
                if (i_reg >= n_reg)
                begin
                    i_next     = '0;
                    state_next = S_MARK;
                end
                else if (k32 >= 32'(act_reg))
                begin
                    status_next = ST_NOROOM;
                    state_next  = S_CR_INIT;
                end
                else
                begin
                    state_next = S_FIT_CHK;
                end
            end
            S_FIT_CHK:
            begin
                if (mem_rdata != '0)
                begin
                    status_next = ST_NOROOM;
                    state_next  = S_CR_INIT;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_FIT_RD;
                end
            end
            S_MARK:
            begin
                if (i_reg >= n_reg)
                begin
                    used_next   = used_reg + CW'(n_reg);
                    gpage_next  = cursor_reg;
                    cursor_next = cursor_reg + CW'(n_reg);
                    ok_next     = 1'b1;
                    state_next  = S_CR_INIT;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = k32[PW-1:0];
                    mem_wdata = rc_reg;
                    i_next    = i_reg + 1'b1;
                end
            end
            S_FCHK_RD:
            begin
                mem_raddr = fk32[PW-1:0];
                if (i_reg >= n_reg)
                begin
                    i_next     = '0;
                    state_next = S_FDEC_RD;
                end
                else
                begin
                    state_next = S_FCHK_CHK;
                end
            end
            S_FCHK_CHK:
            begin
                if (mem_rdata == '0)
                begin
                    status_next = ST_INVALID;
                    state_next  = S_CR_INIT;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_FCHK_RD;
                end
            end
            S_FDEC_RD:
            begin
                mem_raddr  = fk32[PW-1:0];
                state_next = (i_reg >= n_reg) ? S_CR_INIT : S_FDEC_WR;
            end
            S_FDEC_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = fk32[PW-1:0];
                mem_wdata = mem_rdata - 8'd1;
                if (mem_rdata == 8'd1 && used_reg != '0)
                begin
                    used_next = used_reg - 1'b1;
                end
                i_next     = i_reg + 1'b1;
                state_next = S_FDEC_RD;
            end
            S_CR_INIT:
            begin
                j_next     = cursor_reg;
                state_next = S_CR1_RD;
            end
            S_CR1_RD:
            begin
                mem_raddr = j_reg[PW-1:0];
                if (j_reg >= act_reg)
                begin
                    run_next   = '0;
                    state_next = S_MUL_G;
                end
                else
                begin
                    state_next = S_CR1_CHK;
                end
            end
            S_CR1_CHK:
            begin
                j_next = j_reg + 1'b1;
                if (mem_rdata != '0)
                begin
                    state_next = S_CR1_RD;
                end
                else
                begin
                    start_next = j_reg;
                    state_next = S_CR2_RD;
                end
            end
            S_CR2_RD:
            begin
                mem_raddr = j_reg[PW-1:0];
                if (j_reg >= act_reg)
                begin
                    run_next   = j_reg - start_reg;
                    state_next = S_MUL_G;
                end
                else
                begin
                    state_next = S_CR2_CHK;
                end
            end
            S_CR2_CHK:
            begin
                if (mem_rdata == '0)
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_CR2_RD;
                end
                else
                begin
                    run_next   = j_reg - start_reg;
                    state_next = S_MUL_G;
                end
            end
            S_MUL_G:
            begin
                granted_next = ok_reg ? prod_sh[SIZE_W-1:0] : '0;
                state_next   = S_MUL_R;
            end
            S_MUL_R:
            begin
                remain_next = prod_sh[SIZE_W-1:0];
                state_next  = S_MUL_C;
            end
            S_MUL_C:
            begin
                clean_next = prod_sh[SIZE_W-1:0];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    o_status_next  = status_reg;
                    o_granted_next = granted_reg;
                    o_used_next    = used32[USED_W-1:0];
                    o_remain_next  = remain_reg;
                    o_clean_next   = clean_reg;
                    o_empty_next   = (used_reg == '0);
                    o_full_next    = (used_reg == act_reg);
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // a register write restarts the clearing pass
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PAGE_BYTES:   pb_next = cfg_data[PB_W-1:0];
                CFG_ACTIVE_PAGES: ap_next = cfg_data[ACT_W-1:0];
                default:          pb_next = pb_reg;
            endcase
            cursor_next   = '0;
            used_next     = '0;
            clr_addr_next = '0;
            clr_res_next  = 1'b0;
            state_next    = S_CLEAR;
        end
    end

endmodule

// ===== rtl/rpra_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
// Depends on rpra_pkg.
module rpra_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rpra_pkg::DVD_W-1:0]  dividend,
    input  logic [rpra_pkg::PM_W-1:0]   divisor,
    output rpra_pkg::div_status_t       stat
);
    import rpra_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [DVD_W-1:0]     quo_reg, quo_next;
    logic [PM_W-1:0]      rem_reg, rem_next;
    logic [PM_W:0]        trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DVD_W-1]};
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = DIV_CNT_W'(DVD_W);
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = PM_W'(trial - {1'b0, divisor});
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[PM_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    assign stat.done      = done_reg;
    assign stat.quotient  = quo_reg;
    assign stat.remainder = rem_reg;

endmodule

// ===== rtl/rpra_ram.sv =====
// Page reference count store: one write port, one read port, registered read.
// Depends on nothing.
module rpra_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);
    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/rpra_chk.sv =====
// Port-level checker for the page ring allocator, bound to the top level.
// Depends on rpra_pkg and refcounted_page_ring_allocator.
module rpra_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [rpra_pkg::STAT_W-1:0]   status,
    input logic [rpra_pkg::SIZE_W-1:0]   granted_offset,
    input logic [rpra_pkg::USED_W-1:0]   used_pages,
    input logic                          is_empty,
    input logic                          is_full,
    input logic                          cfg_we
);
    import rpra_pkg::*;

    // a result is held until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped before it was taken");

    // every request or register write keeps the block busy for a while
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) || cfg_we |=> !req_ready)
        else $error("ready high right after a request or config write");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (is_empty == (used_pages == '0)))
        else $error("is_empty disagrees with used_pages");

    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && is_full |-> !is_empty)
        else $error("full and empty together");

    a_grant: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ST_OK |-> granted_offset == '0)
        else $error("offset granted on a failed request");

endmodule

bind refcounted_page_ring_allocator rpra_chk u_rpra_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .status         (rsp.status),
    .granted_offset (rsp.granted_offset),
    .used_pages     (rsp.used_pages),
    .is_empty       (rsp.is_empty),
    .is_full        (rsp.is_full),
    .cfg_we         (cfg_we)
);

// ===== dv/rpra_checker.sv =====
// Checker for the page ring allocator: tracks page counts, cursor and config,
// predicts each response and compares it with what the block returns.
// Depends on rpra_pkg and rpra_if.
module rpra_checker #(
    parameter int NUM_PAGES = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    rpra_req_if                            req,
    rpra_rsp_if                            rsp,
    input  logic                           cfg_we,
    input  logic [rpra_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rpra_pkg::CFG_W-1:0]     cfg_data,
    output int                             errors,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import rpra_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SIZE_W-1:0] granted_offset;
        logic [USED_W-1:0] used_pages;
        logic [SIZE_W-1:0] remaining_bytes;
        logic [SIZE_W-1:0] clean_run_bytes;
        logic              is_empty;
        logic              is_full;
    } outcome_t;

    logic [7:0]     page_refs_m [NUM_PAGES];
    int unsigned    cursor;
    int unsigned    busy_pages;
    logic [PB_W-1:0]  page_bytes_r;
    logic [ACT_W-1:0] active_r;
    // expected responses in request order; at most two are ever outstanding
    outcome_t       outcome_mem [4];
    logic [1:0]     rd_ptr;
    logic [1:0]     wr_ptr;
    int             held;

    function automatic int unsigned page_size();
        int unsigned p;
        p = page_bytes_r;
        if (p == 0)
            return 512;
        return (p + 511) & ~32'd511;
    endfunction

    function automatic int unsigned active_count();
        int unsigned a;
        int unsigned lim;
        a = active_r;
        lim = 33554432 / page_size();
        if (a < 1) a = 1;
        if (a > NUM_PAGES) a = NUM_PAGES;
        if (a > lim) a = lim;
        return a;
    endfunction

    function automatic int unsigned clean_pages(input int unsigned act);
        int unsigned i;
        int unsigned j;
        i = cursor;
        while (i < act && page_refs_m[i] != 0)
            i++;
        if (i >= act)
            return 0;
        j = i + 1;
        while (j < act && page_refs_m[j] == 0)
            j++;
        return j - i;
    endfunction

    task automatic wipe();
        foreach (page_refs_m[i])
            page_refs_m[i] = '0;
        cursor = 0;
        busy_pages = 0;
    endtask

    task automatic predict(input logic [OP_W-1:0] op, input logic [RC_W-1:0] rc,
                           input logic [SIZE_W-1:0] size, input logic [OFF_W-1:0] off,
                           output outcome_t e);
        int unsigned pg;
        int unsigned act;
        int unsigned n;
        int unsigned idx;
        int unsigned k;
        int unsigned granted;
        logic [STAT_W-1:0] st;
        bit ok;
        pg = page_size();
        act = active_count();
        n = size / pg + (((size % pg) != 0) ? 1 : 0);
        st = ST_OK;
        granted = 0;
        if (cursor > act)
            cursor = act;
        case (op)
            OP_ALLOC: begin
                if (rc == 0)
                    st = ST_INVALID;
                else if (act - busy_pages < n)
                    st = ST_NOROOM;
                else
                begin
                    ok = 1;
                    while (cursor < act && page_refs_m[cursor] != 0)
                        cursor++;
                    // run would overrun the last active page: restart at page 0
                    if (cursor + n > act)
                    begin
                        cursor = 0;
                        if (page_refs_m[0] != 0)
                            ok = 0;
                    end
                    for (int unsigned i = 1; ok && i < n; i++)
                    begin
                        k = cursor + i;
                        if (k >= act || page_refs_m[k] != 0)
                            ok = 0;
                    end
                    if (!ok)
                        st = ST_NOROOM;
                    else
                    begin
                        for (int unsigned i = 0; i < n; i++)
                            page_refs_m[cursor + i] = rc;
                        busy_pages += n;
                        granted = cursor * pg;
                        cursor += n;
                    end
                end
            end
            OP_FREE: begin
                idx = off / pg;
                if ((off % pg) != 0 || idx >= act || n > act - idx)
                    st = ST_INVALID;
                else
                begin
                    for (int unsigned i = 0; i < n; i++)
                        if (page_refs_m[idx + i] == 0)
                            st = ST_INVALID;
                    if (st == ST_OK)
                        for (int unsigned i = 0; i < n; i++)
                        begin
                            page_refs_m[idx + i] = page_refs_m[idx + i] - 8'd1;
                            if (page_refs_m[idx + i] == 0 && busy_pages > 0)
                                busy_pages--;
                        end
                end
            end
            OP_CLEAR: wipe();
            default: st = ST_INVALID;
        endcase
        e.status          = st;
        e.granted_offset  = granted[SIZE_W-1:0];
        e.used_pages      = busy_pages[USED_W-1:0];
        e.remaining_bytes = SIZE_W'((act - busy_pages) * pg);
        e.clean_run_bytes = SIZE_W'(clean_pages(act) * pg);
        e.is_empty        = (busy_pages == 0);
        e.is_full         = (busy_pages == act);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t e;
        outcome_t got;
        if (!rst_n)
        begin
            page_bytes_r = PB_RESET;
            active_r = ACT_RESET;
            wipe();
            rd_ptr = '0;
            wr_ptr = '0;
            held = 0;
            errors = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got = '{rsp.status, rsp.granted_offset, rsp.used_pages, rsp.remaining_bytes,
                        rsp.clean_run_bytes, rsp.is_empty, rsp.is_full};
                if (held == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: response with no request outstanding", $realtime);
                end
                else
                begin
                    e = outcome_mem[rd_ptr];
                    rd_ptr = rd_ptr + 2'd1;
                    held--;
                    if (got !== e)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("%0t: mismatch (expected/actual)", $realtime);
                            $display("  st %0d/%0d off %0d/%0d used %0d/%0d",
                                     e.status, got.status, e.granted_offset,
                                     got.granted_offset, e.used_pages, got.used_pages);
                            $display("  rem %0d/%0d run %0d/%0d empty %0d/%0d full %0d/%0d",
                                     e.remaining_bytes, got.remaining_bytes,
                                     e.clean_run_bytes, got.clean_run_bytes,
                                     e.is_empty, got.is_empty, e.is_full, got.is_full);
                        end
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_PAGE_BYTES)
                    page_bytes_r = cfg_data[PB_W-1:0];
                else
                    active_r = cfg_data[ACT_W-1:0];
                wipe();
            end
            if (req.valid && req.ready)
            begin
                predict(req.op, req.ref_count, req.size_bytes, req.offset_bytes, e);
                outcome_mem[wr_ptr] = e;
                wr_ptr = wr_ptr + 2'd1;
                held++;
            end
        end
        pending = held;
    end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the page ring allocator: clock, reset, request stimulus,
// response back-pressure and config phases; checking is done in rpra_checker.
// Depends on rpra_pkg, rpra_if, rpra_checker and the block itself.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rpra_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 req_taken;
    int                   errors;
    int                   pending;
    bit                   calm;
    int                   sent;
    int                   rsp_hold;
    int unsigned          cur_pb;
    int unsigned          cur_act;

    rpra_req_if req_ch ();
    rpra_rsp_if rsp_ch ();

    refcounted_page_ring_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rpra_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
        req_taken <= req_ch.valid && req_ch.ready;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(negedge clk)
    begin
        if (rsp_hold > 0)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_hold--;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            rsp_hold = gap_len();
        end
    end

    function automatic int unsigned pg_now();
        if (cur_pb == 0)
            return 512;
        return (cur_pb + 511) & ~32'd511;
    endfunction

    function automatic int unsigned act_now();
        int unsigned a;
        a = cur_act & 32'h1FFF;
        if (a < 1) a = 1;
        if (a > 4096) a = 4096;
        if (a > 33554432 / pg_now()) a = 33554432 / pg_now();
        return a;
    endfunction

    task automatic send(input logic [OP_W-1:0] op, input int unsigned rc,
                        input int unsigned size, input int unsigned off);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.op           <= op;
        req_ch.ref_count    <= rc[RC_W-1:0];
        req_ch.size_bytes   <= size[SIZE_W-1:0];
        req_ch.offset_bytes <= off[OFF_W-1:0];
        @(negedge clk);
        while (!req_taken)
            @(negedge clk);
        sent++;
    endtask

    // byte size covering n pages, with a random tail in the last page
    function automatic int unsigned span_bytes(input int unsigned n);
        if (n == 0)
            return 0;
        return (n - 1) * pg_now() + $urandom_range(1, pg_now());
    endfunction

    task automatic random_request();
        int r;
        int unsigned pg;
        int unsigned act;
        int unsigned n;
        int unsigned rc;
        logic [OP_W-1:0] op;
        pg = pg_now();
        act = act_now();
        r = $urandom_range(0, 99);
        if (r < 46)
        begin
            rc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 3);
            if ($urandom_range(0, 9) == 0)
                n = $urandom_range(0, act);
            else
                n = $urandom_range(0, (act < 4) ? act : 4);
            send(OP_ALLOC, rc, span_bytes(n), $urandom);
        end
        else if (r < 90)
        begin
            n = $urandom_range(0, 3);
            send(OP_FREE, $urandom, span_bytes(n), $urandom_range(0, act - 1) * pg);
        end
        else if (r < 93)
            send(OP_CLEAR, $urandom, $urandom, $urandom);
        else if (r < 95)
            send(OP_RSVD, $urandom, $urandom, $urandom);
        else
        begin
            op = OP_W'($urandom);
            send(op, $urandom, ($urandom_range(0, 7) == 0) ? 33554432 : $urandom, $urandom);
        end
    endtask

    task automatic set_config(input int unsigned pb, input int unsigned act);
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        // let any clearing pass finish before touching the registers
        repeat (5000) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PAGE_BYTES;
        cfg_data  <= pb[CFG_W-1:0];
        @(negedge clk);
        cfg_index <= CFG_ACTIVE_PAGES;
        cfg_data  <= act[CFG_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_pb  = pb;
        cur_act = act;
    endtask

    initial
    begin
        int unsigned phase_pb  [7] = '{0, 513, 512, 1000, 131071, 65536, 4096};
        int unsigned phase_act [7] = '{0, 16, 8, 40, 300, 8191, 24};
        int          phase_len [7] = '{80, 250, 250, 250, 120, 100, 200};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.op = OP_ALLOC;
        req_ch.ref_count = '0;
        req_ch.size_bytes = '0;
        req_ch.offset_bytes = '0;
        rsp_ch.ready = 1'b0;
        rsp_hold = 0;
        sent = 0;
        calm = 0;
        cur_pb = 1024;
        cur_act = 4096;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // directed requests on the reset config: 1 KiB pages, 4096 pages
        send(OP_ALLOC, 0, 1024, 0);                // zero reference count
        send(OP_ALLOC, 5, 0, 0);                   // zero size allocate
        send(OP_ALLOC, 255, 1, 0);
        send(OP_ALLOC, 1, 3000, 0);                // three pages
        send(OP_FREE, 0, 1024, 1);                 // unaligned
        send(OP_FREE, 0, 1024, 0);
        send(OP_FREE, 0, 3072, 1024);
        send(OP_FREE, 0, 0, 2048);                 // zero size free
        send(OP_FREE, 0, 2048, 4095 * 1024);       // runs past the end
        send(OP_FREE, 0, 1024, 10 * 1024);         // page with no references
        send(OP_RSVD, 255, 33554432, 33554431);
        send(OP_ALLOC, 1, 33554432, 0);            // more than is free
        send(OP_ALLOC, 1, 4095 * 1024, 0);         // wraps onto busy page 0
        send(OP_CLEAR, 0, 0, 0);
        send(OP_ALLOC, 7, 33554432, 0);            // 32 MiB, more than the active pages hold
        send(OP_FREE, 0, 1024, 33553408);
        send(OP_ALLOC, 2, 1024, 0);                // one page, granted at page 0
        send(OP_ALLOC, 2, 1024, 0);
        send(OP_FREE, 0, 33554432, 0);
        send(OP_FREE, 0, 1, 33554431);
        send(OP_CLEAR, 255, 33554432, 33554431);
        repeat (25) random_request();

        for (int p = 0; p < 7; p++)
        begin
            set_config(phase_pb[p], phase_act[p]);
            calm = ($urandom_range(0, 2) == 0);
            repeat (phase_len[p]) random_request();
        end

        req_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        $display("Sent %0d requests over the reset config and 7 further page layouts,",
                 sent);
        $display("with random gaps and response back-pressure; %0d errors.", errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #500ms;
        $display("Timed out with %0d responses outstanding", pending);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rpra_pkg.sv
rtl/rpra_if.sv
rtl/rpra_div.sv
rtl/rpra_ram.sv
rtl/refcounted_page_ring_allocator.sv
rtl/rpra_chk.sv
dv/rpra_checker.sv
dv/tb_top.sv
